[rtl/core/vn3_pkg.sv]
// ============================================================================
// vn3_pkg
// Shared types and constants for the 3-D vector normaliser.
// ============================================================================
package vn3_pkg;

    // The width of an input component, fixed by the request format.
    localparam int IN_WIDTH  = 32;
    // The width of a result component, also fixed by the result format.
    localparam int OUT_WIDTH = 32;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] comp_x_in;
        logic signed [IN_WIDTH-1:0] comp_y_in;
        logic signed [IN_WIDTH-1:0] comp_z_in;
    } vec_req_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        zero_length;
    } vec_res_t;

    // Per-request side information that travels down the pipeline with the valid bit.
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } vn3_side_t;

endpackage

[rtl/core/vn3_lane.sv]
// ============================================================================
// vn3_lane
// One component: restoring divide of M * 2^(2F) by S, then a bit-serial
// integer square root of the quotient, one bit per register stage.
// ============================================================================
module vn3_lane
    import vn3_pkg::*;
#(
    parameter int SW = 64,
    parameter int F  = 30
)
(
    input  logic          clk,
    input  logic          adv,
    input  logic [SW-1:0] mag_sq,
    input  logic [SW-1:0] sum_sq,
    output logic [F:0]    root
);

    localparam int DB = 2 * F + 1;   // quotient bits
    localparam int RW = SW + 1;      // remainder width (holds up to 2S)
    localparam int TW = 2 * F + 3;   // square-root working width

    logic [RW-1:0] rem_reg [0:DB-1];
    logic [SW-1:0] div_reg [0:DB-1];
    logic [DB-1:0] quo_reg [0:DB-1];

    logic [TW-1:0] sr_rem_reg  [0:F];
    logic [F:0]    sr_root_reg [0:F];

    genvar k;
    generate
        for (k = 0; k < DB; k++) begin : g_div
            logic [RW-1:0] r_in;
            logic [SW-1:0] s_in;
            logic [DB-1:0] q_in;
            logic [RW-1:0] diff;
            logic          take;

            if (k == 0) begin : g_first
                assign r_in = {1'b0, mag_sq};
                assign s_in = sum_sq;
                assign q_in = '0;
            end
            else begin : g_next
                // append the next (zero) dividend bit
                assign r_in = {rem_reg[k-1][RW-2:0], 1'b0};
                assign s_in = div_reg[k-1];
                assign q_in = quo_reg[k-1];
            end

            assign diff = r_in - {1'b0, s_in};
            assign take = (r_in >= {1'b0, s_in});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= take ? diff : r_in;
                    div_reg[k] <= s_in;
                    quo_reg[k] <= {q_in[DB-2:0], take};
                end
            end
        end

        for (k = 0; k <= F; k++) begin : g_sqrt
            localparam int B = F - k;
            logic [TW-1:0] rm_in;
            logic [F:0]    rt_in;
            logic [TW-1:0] trial;
            logic          take;

            if (k == 0) begin : g_first
                assign rm_in = {{(TW-DB){1'b0}}, quo_reg[DB-1]};
                assign rt_in = '0;
            end
            else begin : g_next
                assign rm_in = sr_rem_reg[k-1];
                assign rt_in = sr_root_reg[k-1];
            end

            assign trial = ({{(TW-F-1){1'b0}}, rt_in} << (B + 1))
                         | ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
            assign take  = (rm_in >= trial);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sr_rem_reg[k]  <= take ? (rm_in - trial) : rm_in;
                    sr_root_reg[k] <= rt_in | ({{F{1'b0}}, take} << B);
                end
            end
        end
    endgenerate

    assign root = sr_root_reg[F];

endmodule

[rtl/core/vector_normalize_3d_top.sv]
// ============================================================================
// vector_normalize_3d_top
// Normalises a signed fixed-point 3-D vector to a unit vector, exact with
// truncation toward zero; a zero vector gives zero components and a flag.
// ============================================================================
// Throughput: one request per cycle while the pipe advances (no result held back
// by a low dst_ready); every lane stage does one quotient bit or one root bit,
// so the depth follows the 2F+1 divide steps and F+1 root steps.
// Reset: rst_n clears all stage valid bits at once; data registers are not reset.
module vector_normalize_3d_top
    import vn3_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 30
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  vec_req_t src_data,
    output logic     dst_valid,
    input  logic     dst_ready,
    output vec_res_t dst_data
);

    localparam int F  = OUT_FRAC_BITS;
    localparam int W  = IN_WIDTH;
    localparam int SW = 2 * W;          // holds the sum of three squares
    localparam int L  = 3 * F + 2;      // lane depth
    localparam int N  = L + 4;          // total stages including output

    // Valid and side information per stage; they advance together with data.
    logic      vld_reg  [0:N-1];
    vn3_side_t side_reg [0:N-1];
    logic      adv;

    // Stage A: magnitudes.  Stage B: squares.  Stage C: sum of squares.
    logic [W-1:0]  mag_reg [0:2];
    logic [SW-1:0] sq_reg  [0:2];
    logic [SW-1:0] msq_reg [0:2];
    logic [SW-1:0] sum_reg;

    logic [W-1:0]  raw   [0:2];
    logic [F:0]    root  [0:2];
    vn3_side_t     side_in;

    // Advance the whole pipe unless a finished result is held back.
    assign adv       = !vld_reg[N-1] || dst_ready;
    assign src_ready = adv;

    assign raw[0] = src_data.comp_x_in;
    assign raw[1] = src_data.comp_y_in;
    assign raw[2] = src_data.comp_z_in;

    always_comb
    begin
        side_in.neg  = {raw[2][W-1], raw[1][W-1], raw[0][W-1]};
        side_in.zero = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= src_valid;
            for (int i = 1; i < N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int c = 0; c < 3; c++)
            begin
                // the most negative value maps to 2^(W-1), which fits unsigned
                mag_reg[c] <= raw[c][W-1] ? (~raw[c] + 1'b1) : raw[c];
                sq_reg[c]  <= {{W{1'b0}}, mag_reg[c]} * {{W{1'b0}}, mag_reg[c]};
                msq_reg[c] <= sq_reg[c];
            end
            // three squares of at most 2^(2W-2) never overflow 2W bits
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            vn3_lane #(
                .SW (SW),
                .F  (F)
            ) u_lane (
                .clk    (clk),
                .adv    (adv),
                .mag_sq (msq_reg[g]),
                .sum_sq (sum_reg),
                .root   (root[g])
            );
        end
    endgenerate

    // Output stage: restore the sign, force zero for a zero-length vector.
    logic [OUT_WIDTH-1:0] unit_next [0:2];
    logic [F+OUT_WIDTH:0] ext       [0:2];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ext[c] = {{OUT_WIDTH{1'b0}}, root[c]};
            if (side_reg[N-2].neg[c])
            begin
                ext[c] = ~ext[c] + 1'b1;
            end
            unit_next[c] = side_reg[N-2].zero ? '0 : ext[c][OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dst_data.unit_x      <= unit_next[0];
            dst_data.unit_y      <= unit_next[1];
            dst_data.unit_z      <= unit_next[2];
            dst_data.zero_length <= side_reg[N-2].zero;
        end
    end

    assign dst_valid = vld_reg[N-1];

    // A zero-length flag always comes with all-zero components.
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.zero_length |->
            dst_data.unit_x == '0 && dst_data.unit_y == '0 && dst_data.unit_z == '0)
        else $error("zero-length result with non-zero components");

    // Hold a stalled result and its flag for the next cycle.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
        else $error("stalled result changed");

    // An empty output stage never blocks a request.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> src_ready)
        else $error("request blocked with empty output");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Checks the 3-D vector normaliser against a bit-exact predictor or typed-in
// results. A table of directed requests comes first, then constrained-by-hand
// random requests. Both handshake sides idle in random bursts.
// ============================================================================
module tb_top;
    import vn3_pkg::*;

    localparam int FRAC       = 30;
    localparam int LATENCY    = 3 * FRAC + 6;
    localparam int N_RANDOM   = 1530;
    localparam int QUIET_FROM = 1300;   // random requests from this one on never idle
    localparam int PAUSE_AT   = 400;    // sender drains the pipeline here
    localparam int CYCLE_CAP  = 400000;

    localparam logic signed [31:0] C_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] C_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] UNIT_P = 32'sh4000_0000;
    localparam logic signed [31:0] UNIT_N = -32'sh4000_0000;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_ready;
    vec_req_t src_data;
    logic     dst_valid;
    logic     dst_ready;
    vec_res_t dst_data;

    vec_res_t unit_pending[$];
    int       fail_count;
    int       cycle_count;
    bit       quiet;

    vector_normalize_3d_top #(.OUT_FRAC_BITS(FRAC)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor: largest q with q^2 * S <= (|c| << FRAC)^2, sign of c applied.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] abs_comp(logic signed [31:0] c);
        return c[31] ? 32'(-c) : 32'(c);
    endfunction

    function automatic logic signed [31:0] unit_comp(logic signed [31:0] c,
                                                     logic [65:0] sum_sq);
        logic [191:0] goal;
        logic [191:0] trial;
        logic [31:0]  mag;
        logic [31:0]  q;
        logic [31:0]  cand;
        mag  = abs_comp(c);
        goal = {160'd0, mag} << FRAC;
        goal = goal * goal;
        q    = '0;
        for (int b = FRAC; b >= 0; b--)
        begin
            cand  = q | (32'd1 << b);
            trial = {160'd0, cand} * {160'd0, cand};
            trial = trial * {126'd0, sum_sq};
            if (trial <= goal)
                q = cand;
        end
        return c[31] ? -$signed(q) : $signed(q);
    endfunction

    function automatic vec_res_t normalise(vec_req_t r);
        vec_res_t    res;
        logic [65:0] sum_sq;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
        mx     = abs_comp(r.comp_x_in);
        my     = abs_comp(r.comp_y_in);
        mz     = abs_comp(r.comp_z_in);
        sum_sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my) + 66'(mz) * 66'(mz);
        res    = '0;
        if (sum_sq == 0)
            res.zero_length = 1'b1;
        else
        begin
            res.unit_x = unit_comp(r.comp_x_in, sum_sq);
            res.unit_y = unit_comp(r.comp_y_in, sum_sq);
            res.unit_z = unit_comp(r.comp_z_in, sum_sq);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: typed-in results only where they are obvious.
    // ------------------------------------------------------------------------
    typedef struct {
        vec_req_t req;
        bit       typed;
        vec_res_t res;
    } vec_row_t;

    vec_row_t vec_table[] = '{
        '{'{32'sd0, 32'sd0, 32'sd0},     1, '{32'sd0, 32'sd0, 32'sd0, 1'b1}},
        '{'{32'sd1, 32'sd0, 32'sd0},     1, '{UNIT_P, 32'sd0, 32'sd0, 1'b0}},
        '{'{-32'sd1, 32'sd0, 32'sd0},    1, '{UNIT_N, 32'sd0, 32'sd0, 1'b0}},
        '{'{32'sd0, C_MIN, 32'sd0},      1, '{32'sd0, UNIT_N, 32'sd0, 1'b0}},
        '{'{32'sd0, 32'sd0, C_MAX},      1, '{32'sd0, 32'sd0, UNIT_P, 1'b0}},
        '{'{32'sd0, C_MAX, 32'sd0},      1, '{32'sd0, UNIT_P, 32'sd0, 1'b0}},
        '{'{C_MIN, 32'sd0, 32'sd0},      1, '{UNIT_N, 32'sd0, 32'sd0, 1'b0}},
        '{'{32'sd0, 32'sd0, -32'sd1},    1, '{32'sd0, 32'sd0, UNIT_N, 1'b0}},
        '{'{C_MIN, C_MIN, C_MIN},        0, '0},
        '{'{C_MAX, C_MAX, C_MAX},        0, '0},
        '{'{C_MAX, C_MIN, C_MAX},        0, '0},
        '{'{32'sd1, 32'sd1, 32'sd1},     0, '0},
        '{'{32'sd3, -32'sd4, 32'sd0},    0, '0},
        '{'{32'sd1, C_MAX, -32'sd1},     0, '0},
        '{'{32'sd2, -32'sd3, 32'sd6},    0, '0},
        '{'{32'sh0001_0000, 32'sd0, 32'sh0001_0000}, 0, '0}
    };

    // ------------------------------------------------------------------------
    // Scoreboard: log each accepted request, compare each accepted result.
    // ------------------------------------------------------------------------
    logic     row_typed;
    vec_res_t row_res;

    always @(posedge clk)
    begin
        vec_res_t want;
        if (rst_n && src_valid && src_ready)
            unit_pending.push_back(row_typed ? row_res : normalise(src_data));
        if (rst_n && dst_valid && dst_ready)
        begin
            if (unit_pending.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = unit_pending.pop_front();
                if (dst_data.unit_x !== want.unit_x)
                begin
                    $error("unit_x exp %0d got %0d", want.unit_x, dst_data.unit_x);
                    fail_count++;
                end
                if (dst_data.unit_y !== want.unit_y)
                begin
                    $error("unit_y exp %0d got %0d", want.unit_y, dst_data.unit_y);
                    fail_count++;
                end
                if (dst_data.unit_z !== want.unit_z)
                begin
                    $error("unit_z exp %0d got %0d", want.unit_z, dst_data.unit_z);
                    fail_count++;
                end
                if (dst_data.zero_length !== want.zero_length)
                begin
                    $error("zero_length exp %0b got %0b",
                           want.zero_length, dst_data.zero_length);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls in bursts; hold ready high once the run goes quiet.
    initial
    begin
        dst_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet || $urandom_range(0, 3) != 0)
            begin
                dst_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                dst_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("vector_normalize_3d_top verification failed");
            $finish;
        end
    end

    // Random component: full range, small, powers of two, zero, extremes, right-shifted.
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom());
            4, 5:       return $signed($urandom_range(0, 512)) - 32'sd256;
            6:          return ($urandom_range(0, 1) ? 32'sd1 : -32'sd1)
                               <<< $urandom_range(0, 30);
            7:          return 32'sd0;
            8:          return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default:    return $signed($urandom()) >>> $urandom_range(1, 28);
        endcase
    endfunction

    // Present one request; advance the payload only once it is taken.
    task automatic send_vec(vec_req_t req, bit typed, vec_res_t res, bit may_idle);
        if (may_idle && $urandom_range(0, 4) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= req;
        row_typed <= typed;
        row_res   <= res;
        do
            @(posedge clk);
        while (!src_ready);
    endtask

    initial
    begin
        vec_req_t req;
        int       tail;
        fail_count  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        row_typed   = 1'b0;
        row_res     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vec_table[i])
            send_vec(vec_table[i].req, vec_table[i].typed, vec_table[i].res, 1'b1);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == PAUSE_AT)
            begin
                // drop valid and let every outstanding result drain
                src_valid <= 1'b0;
                do
                    @(posedge clk);
                while (unit_pending.size() != 0);
            end
            if (n == QUIET_FROM)
                quiet = 1'b1;
            req.comp_x_in = rand_comp();
            req.comp_y_in = rand_comp();
            req.comp_z_in = rand_comp();
            send_vec(req, 1'b0, '0, !quiet);
        end
        src_valid <= 1'b0;

        while (unit_pending.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < LATENCY + 20)
        begin
            @(posedge clk);
            tail++;
        end

        if (fail_count == 0)
            $display("vector_normalize_3d_top verification clean");
        else
            $display("vector_normalize_3d_top verification failed");
        $finish;
    end

endmodule
